// ----- hw/rtl/tpt_pkg.sv -----
// Shared types and constants for the tensor permute/transpose block.
package tpt_pkg;

  localparam int IDX_W        = 10;
  localparam int DATA_W       = 32;
  localparam int DIM_W        = 11;
  localparam int FDIMS        = 4;
  localparam int CFG_W        = 44;
  localparam int CNT_W        = 3;
  localparam int PERM_W       = 2;
  localparam int CFG_IDX_W    = 3;
  localparam int SAT_W        = 17;
  localparam int DEPTH_DEF    = 1024;
  localparam int MAX_DIMS_DEF = 4;
  localparam int STEP_BITS    = 2;
  localparam int DSTEPS       = (IDX_W + STEP_BITS - 1) / STEP_BITS;
  localparam int DIV_W        = DIM_W + IDX_W;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_PERM  = 2'd2,
    ST_ADDR  = 2'd3
  } status_t;

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_FETCH = 1'b1
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DIMS  = 3'd0,
    REG_SRC   = 3'd1,
    REG_DST   = 3'd2,
    REG_PERM  = 3'd3,
    REG_CONJ  = 3'd4
  } cfg_reg_t;

  // One item in flight through the address pipeline.
  typedef struct packed {
    cmd_t                  cmd;
    logic [IDX_W-1:0]      idx;
    logic [2*DATA_W-1:0]   data;
    status_t               status;
    logic [IDX_W-1:0]      rest;
    logic [IDX_W-1:0]      quot;
    logic [SAT_W-1:0]      term;
    logic [SAT_W-1:0]      addr;
  } item_t;

endpackage

// ----- hw/rtl/tensor_permute_transpose.sv -----
// Tensor permute/transpose: address pipeline in front of one element store.
// An item passes a capture stage, then for each of NDIM dimensions the divide stages,
// a multiply stage and an add stage, then the result register (NDIM = min(MAX_DIMS, 4)).
// Throughput: one item per cycle unless out_ready or the settle hold-off stalls it; the
// elastic stage chain and the single-port-per-side element store each take one item a cycle,
// so the store port sets the rate. Reset: configuration returns to its reset values; the
// element store is not cleared. After reset and after each configuration write, input is
// held off while the registered stride and element-count products settle.
module tensor_permute_transpose
  import tpt_pkg::*;
#(
  parameter int DEPTH    = DEPTH_DEF,
  parameter int MAX_DIMS = MAX_DIMS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  // config write port
  input  logic                        cfg_write,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [CFG_W-1:0]            cfg_data,
  // input channel
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        command,
  input  logic [IDX_W-1:0]            index,
  input  logic signed [DATA_W-1:0]    value_real,
  input  logic signed [DATA_W-1:0]    value_imag,
  // result channel
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [DATA_W-1:0]    out_real,
  output logic signed [DATA_W-1:0]    out_imag,
  output logic [1:0]                  status
);

  localparam int NDIM   = (MAX_DIMS < FDIMS) ? MAX_DIMS : FDIMS;
  localparam int AW     = $clog2(DEPTH);
  localparam int SPD    = DSTEPS + 2;          // stages per dimension: divide, multiply, add
  localparam int NSTG   = 1 + NDIM * SPD;
  localparam int SETTLE = FDIMS + 2;
  localparam int SET_W  = $clog2(SETTLE + 1);
  localparam logic [DIM_W-1:0] DCAP = DIM_W'(1 << IDX_W);
  localparam logic [SAT_W-1:0] SCAP = SAT_W'(DEPTH);

  // Saturating products: any value at or above the cap behaves the same downstream.
  function automatic logic [DIM_W-1:0] sat_dst(input logic [DIM_W-1:0] a,
                                               input logic [DIM_W-1:0] b);
    logic [2*DIM_W-1:0] p;
    p = a * b;
    return (p > (2*DIM_W)'(DCAP)) ? DCAP : p[DIM_W-1:0];
  endfunction

  function automatic logic [SAT_W-1:0] sat_src(input logic [DIM_W-1:0] a,
                                               input logic [SAT_W-1:0] b);
    logic [DIM_W+SAT_W-1:0] p;
    p = a * b;
    return (p > (DIM_W+SAT_W)'(SCAP)) ? SCAP : p[SAT_W-1:0];
  endfunction

  function automatic logic [SAT_W-1:0] sat_term(input logic [IDX_W-1:0] a,
                                                input logic [SAT_W-1:0] b);
    logic [IDX_W+SAT_W-1:0] p;
    p = a * b;
    return (p > (IDX_W+SAT_W)'(SCAP)) ? SCAP : p[SAT_W-1:0];
  endfunction

  // ---------------- configuration ----------------
  logic [CNT_W-1:0]  dims_cnt;
  logic [CFG_W-1:0]  src_shape;
  logic [CFG_W-1:0]  dst_shape;
  logic [7:0]        perm;
  logic              conj;
  logic [SET_W-1:0]  settle;

  always_ff @(posedge clk) begin
    if (rst) begin
      dims_cnt  <= CNT_W'(2);
      src_shape <= '0;
      dst_shape <= '0;
      perm      <= '0;
      conj      <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_DIMS: dims_cnt  <= cfg_data[CNT_W-1:0];
        REG_SRC:  src_shape <= cfg_data;
        REG_DST:  dst_shape <= cfg_data;
        REG_PERM: perm      <= cfg_data[7:0];
        REG_CONJ: conj      <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // hold off input until derived products are stable
  always_ff @(posedge clk) begin
    if (rst || cfg_write) begin
      settle <= SET_W'(SETTLE);
    end else if (settle != '0) begin
      settle <= settle - SET_W'(1);
    end
  end

  logic [CNT_W-1:0] n_act;
  assign n_act = (dims_cnt > CNT_W'(NDIM)) ? CNT_W'(NDIM) : dims_cnt;

  // ---------------- derived strides ----------------
  // Inactive dimensions count as size 1, so one product chain serves any count.
  logic [DIM_W-1:0] deff   [FDIMS];
  logic [DIM_W-1:0] seff   [FDIMS];
  logic [DIM_W-1:0] dst_st [FDIMS];
  logic [SAT_W-1:0] src_st [FDIMS];
  logic [DIM_W-1:0] elem_cnt;

  always_ff @(posedge clk) begin
    for (int j = 0; j < FDIMS; j++) begin
      deff[j] <= (CNT_W'(j) < n_act) ? dst_shape[DIM_W*j +: DIM_W] : DIM_W'(1);
      seff[j] <= (CNT_W'(j) < n_act) ? src_shape[DIM_W*j +: DIM_W] : DIM_W'(1);
    end
    dst_st[FDIMS-1] <= DIM_W'(1);
    src_st[FDIMS-1] <= SAT_W'(1);
    for (int k = 0; k < FDIMS-1; k++) begin
      dst_st[k] <= sat_dst(deff[k+1], dst_st[k+1]);
      src_st[k] <= sat_src(seff[k+1], src_st[k+1]);
    end
    elem_cnt <= (n_act == '0) ? '0 : sat_dst(deff[0], dst_st[0]);
  end

  // ---------------- entry checks ----------------
  logic    perm_bad;
  status_t entry_st;

  always_comb begin
    perm_bad = 1'b0;
    for (int d = 0; d < NDIM; d++) begin
      if (CNT_W'(d) < n_act && CNT_W'(perm[PERM_W*d +: PERM_W]) >= n_act) begin
        perm_bad = 1'b1;
      end
    end
    if (cmd_t'(command) == CMD_WRITE) begin
      entry_st = ({22'b0, index} >= 32'(DEPTH)) ? ST_ADDR : ST_OK;
    end else if ({1'b0, index} >= elem_cnt) begin
      entry_st = ST_RANGE;
    end else if (perm_bad) begin
      entry_st = ST_PERM;
    end else begin
      entry_st = ST_OK;
    end
  end

  // ---------------- elastic address pipeline ----------------
  item_t pipe [NSTG];
  item_t nxt  [NSTG];
  logic  v    [NSTG];
  logic  adv  [NSTG];
  logic  space_out;
  logic  accept;

  assign space_out = !out_valid || out_ready;

  always_comb begin
    adv[NSTG-1] = v[NSTG-1] && space_out;
    for (int k = NSTG-2; k >= 0; k--) begin
      adv[k] = v[k] && (!v[k+1] || adv[k+1]);
    end
  end

  assign in_ready = (!v[0] || adv[0]) && (settle == '0);
  assign accept   = in_valid && in_ready;

  // stage 0 captures the transfer; stage k computes from stage k-1
  always_comb begin
    item_t            p;
    int               j, d, t, b;
    logic [DIM_W-1:0] dv;
    logic [DIV_W-1:0] sh;
    logic [IDX_W-1:0] coord;
    logic [SAT_W:0]   sum;
    nxt[0].cmd    = cmd_t'(command);
    nxt[0].idx    = index;
    nxt[0].data   = {value_imag, value_real};
    nxt[0].status = entry_st;
    nxt[0].rest   = index;
    nxt[0].quot   = '0;
    nxt[0].term   = '0;
    nxt[0].addr   = '0;
    for (int k = 1; k < NSTG; k++) begin
      p  = pipe[k-1];
      j  = k - 1;
      d  = j / SPD;
      t  = j % SPD;
      dv = dst_st[d];
      if (t < DSTEPS) begin
        // restoring divide, STEP_BITS quotient bits per stage
        for (int i = 0; i < STEP_BITS; i++) begin
          b = IDX_W - 1 - (t * STEP_BITS + i);
          if (b >= 0) begin
            sh = DIV_W'(dv) << b;
            if (DIV_W'(p.rest) >= sh) begin
              p.rest    = p.rest - IDX_W'(sh);
              p.quot[b] = 1'b1;
            end
          end
        end
      end else if (t == DSTEPS) begin
        coord  = (CNT_W'(d) < n_act && dv != '0) ? p.quot : '0;
        p.term = sat_term(coord, src_st[perm[PERM_W*d +: PERM_W]]);
      end else begin
        sum    = {1'b0, p.addr} + {1'b0, p.term};
        p.addr = (sum > {1'b0, SCAP}) ? SCAP : sum[SAT_W-1:0];
        p.quot = '0;
      end
      nxt[k] = p;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NSTG; k++) v[k] <= 1'b0;
    end else begin
      v[0] <= accept ? 1'b1 : (adv[0] ? 1'b0 : v[0]);
      for (int k = 1; k < NSTG; k++) begin
        v[k] <= adv[k-1] ? 1'b1 : (adv[k] ? 1'b0 : v[k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) pipe[0] <= nxt[0];
    for (int k = 1; k < NSTG; k++) begin
      if (adv[k-1]) pipe[k] <= nxt[k];
    end
  end

  // ---------------- element store ----------------
  item_t               last;
  status_t             fin_st;
  logic                mem_we, mem_re;
  logic [2*DATA_W-1:0] mem [DEPTH];
  logic [2*DATA_W-1:0] rdata;

  assign last   = pipe[NSTG-1];
  assign fin_st = (last.cmd == CMD_FETCH && last.status == ST_OK && last.addr >= SCAP) ?
                  ST_ADDR : last.status;
  assign mem_we = adv[NSTG-1] && last.cmd == CMD_WRITE && last.status == ST_OK;
  assign mem_re = adv[NSTG-1] && last.cmd == CMD_FETCH && fin_st == ST_OK;

  // writes and reads land in item order, so a fetch always sees earlier writes
  always_ff @(posedge clk) begin
    if (mem_we) mem[AW'(last.idx)] <= last.data;
    if (mem_re) rdata <= mem[last.addr[AW-1:0]];
  end

  // ---------------- result register ----------------
  status_t out_st;
  logic    out_fetch;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv[NSTG-1]) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[NSTG-1]) begin
      out_st    <= fin_st;
      out_fetch <= (last.cmd == CMD_FETCH);
    end
  end

  logic out_ok;
  assign out_ok   = out_fetch && out_st == ST_OK;
  assign status   = out_st;
  assign out_real = out_ok ? rdata[DATA_W-1:0] : '0;
  assign out_imag = !out_ok ? '0 :
                    (conj ? (DATA_W'(0) - rdata[2*DATA_W-1:DATA_W]) : rdata[2*DATA_W-1:DATA_W]);

`ifndef SYNTHESIS
  a_settle_block: assert property (@(posedge clk) disable iff (rst)
    (settle != '0) |-> !in_ready) else $error("input taken while strides settle");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_st != ST_OK) |-> (out_real == '0 && out_imag == '0))
    else $error("error result carries data");

  a_one_port: assert property (@(posedge clk) disable iff (rst)
    !(mem_we && mem_re)) else $error("store written and read by one item");

  a_out_from_pipe: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !$past(out_valid)) |-> $past(v[NSTG-1]))
    else $error("result without an item in the last stage");
`endif

endmodule
